/* rtl/tqvg_pkg.sv */
// tile quad vertex generator: shared types and constants
// no dependencies; imported by the divider and the top level
`default_nettype none

package tqvg_pkg;

    // vertices per tile, two triangles
    localparam int unsigned VERTS_PER_TILE = 6;
    localparam logic [2:0] CORNER_LAST = 3'd5;

    // corner offsets in tile units, bit k belongs to corner k
    localparam logic [5:0] CORNER_DX = 6'b110010;
    localparam logic [5:0] CORNER_DY = 6'b101100;

    localparam logic [24:0] TEX_X_MAX = 25'd32767;

    // register map, index is byte address / 4
    typedef enum logic [2:0] {
        REG_TILE_WIDTH    = 3'd0,
        REG_TILE_HEIGHT   = 3'd1,
        REG_TEXTURE_WIDTH = 3'd2,
        REG_MAP_WIDTH     = 3'd3,
        REG_MAP_HEIGHT    = 3'd4
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COLS,
        ST_DIV_COLS,
        ST_DIV_IDX,
        ST_MUL_PX,
        ST_MUL_PY,
        ST_MUL_TX,
        ST_MUL_TY,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic        start;
        logic [15:0] dividend;
        logic [14:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [15:0] quotient;
        logic [14:0] remainder;
    } div_rsp_t;

endpackage

`default_nettype wire

/* rtl/tqvg_in_if.sv */
// tile index channel: valid/ready handshake with the tile index payload
// depends on nothing
`default_nettype none

interface tqvg_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] tile_index;

    modport source (output valid, output tile_index, input ready);
    modport sink   (input valid, input tile_index, output ready);
endinterface

`default_nettype wire

/* rtl/tqvg_out_if.sv */
// vertex channel: valid/ready handshake with one vertex as payload
// depends on nothing
`default_nettype none

interface tqvg_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  corner;
    logic [20:0] pos_x;
    logic [20:0] pos_y;
    logic [14:0] tex_x;
    logic [24:0] tex_y;
    logic        tile_done;

    modport source (output valid, output corner, output pos_x, output pos_y,
                    output tex_x, output tex_y, output tile_done, input ready);
    modport sink   (input valid, input corner, input pos_x, input pos_y,
                    input tex_x, input tex_y, input tile_done, output ready);
endinterface

`default_nettype wire

/* rtl/tqvg_div.sv */
// restoring divider, one quotient bit per cycle, 16 steps
// depends on tqvg_pkg
`default_nettype none

module tqvg_div
    import tqvg_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [14:0] dvsr_reg, dvsr_next;
    logic [15:0] quo_reg, quo_next;
    logic [14:0] rem_reg, rem_next;

    logic [15:0] trial;
    logic [16:0] diff;

    always_comb
    begin
        trial = {rem_reg, quo_reg[15]};
        diff  = {1'b0, trial} - {2'b00, dvsr_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvsr_next = dvsr_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;

        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = 4'd0;
            dvsr_next = req.divisor;
            quo_next  = req.dividend;
            rem_next  = 15'd0;
        end
        else if (busy_reg)
        begin
            // borrow means the trial remainder stays
            if (diff[16])
            begin
                rem_next = trial[14:0];
            end
            else
            begin
                rem_next = diff[14:0];
            end
            quo_next = {quo_reg[14:0], ~diff[16]};
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'd15)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 4'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvsr_reg <= dvsr_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

`default_nettype wire

/* rtl/tile_quad_vertex_generator_unit.sv */
// tile quad vertex generator top level: register file, sequencer, shared multiplier
// depends on tqvg_pkg, tqvg_in_if, tqvg_out_if and tqvg_div
//
// usage
// - tile_in carries one tile index per transaction, in row-major map order;
//   each one produces six vertex transactions on vertex_out, corners 0..5,
//   with tile_done set on corner 5
// - the block keeps the current map cell and advances it after each tile,
//   wrapping at map_width columns and map_height rows (and at 4096 either way)
// - the apb port holds tile_width, tile_height, texture_width, map_width and
//   map_height at byte addresses 0, 4, 8, 12, 16; pready is always high;
//   write only while the block is idle
// - a tile is accepted, then ST_COLS launches the 16-step shared divider,
//   which splits the index into tileset column and row, one shared 16x9
//   multiplier forms the four base coordinates, then one vertex per cycle
//   goes into the output register while that register can take it
// - after a write to tile_width or texture_width the next tile first runs
//   the divider once more for the tileset column count, unless tile_width is zero
// - tile_in.ready is high only while idle; the next tile can be accepted
//   while the last vertex still waits in the output register
// - a stalled vertex_out holds its vertex and the sequencer waits
// - reset restores register defaults, clears the map cell to column 0 row 0
//   and empties the output register
`default_nettype none

module tile_quad_vertex_generator_unit
    import tqvg_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    tqvg_in_if.sink          tile_in,
    tqvg_out_if.source       vertex_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // configuration registers
    logic [8:0]  tile_width_reg;
    logic [8:0]  tile_height_reg;
    logic [14:0] texture_width_reg;
    logic [12:0] map_width_reg;
    logic [12:0] map_height_reg;
    logic        cfg_wr;
    reg_idx_t    cfg_idx;

    // sequencer and working registers
    state_t      state_reg, state_next;
    logic [14:0] cols_reg, cols_next;
    logic        cols_ok_reg, cols_ok_next;
    logic [15:0] idx_reg, idx_next;
    logic [14:0] tcol_reg, tcol_next;
    logic [15:0] trow_reg, trow_next;
    logic [20:0] base_px_reg, base_px_next;
    logic [20:0] base_py_reg, base_py_next;
    logic [23:0] base_tx_reg, base_tx_next;
    logic [24:0] base_ty_reg, base_ty_next;
    logic [2:0]  corner_reg, corner_next;
    logic [11:0] cell_col_reg, cell_col_next;
    logic [11:0] cell_row_reg, cell_row_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic [2:0]  out_corner_reg, out_corner_next;
    logic [20:0] out_pos_x_reg, out_pos_x_next;
    logic [20:0] out_pos_y_reg, out_pos_y_next;
    logic [14:0] out_tex_x_reg, out_tex_x_next;
    logic [24:0] out_tex_y_reg, out_tex_y_next;
    logic        out_done_reg, out_done_next;

    // shared units
    div_req_t    div_req;
    div_rsp_t    div_rsp;
    logic [15:0] mul_a;
    logic [8:0]  mul_b;
    logic [24:0] mul_prod;

    // vertex arithmetic
    logic [8:0]  ox;
    logic [8:0]  oy;
    logic [24:0] tx_sum;
    logic [12:0] col_inc;
    logic [12:0] row_inc;
    logic        col_wrap;
    logic        row_wrap;
    logic        out_free;

    tqvg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // ---------------------------------------------------------------
    // apb register file
    // ---------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_width_reg    <= 9'd16;
            tile_height_reg   <= 9'd16;
            texture_width_reg <= 15'd256;
            map_width_reg     <= 13'd64;
            map_height_reg    <= 13'd64;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_TILE_WIDTH:    tile_width_reg    <= pwdata[8:0];
                REG_TILE_HEIGHT:   tile_height_reg   <= pwdata[8:0];
                REG_TEXTURE_WIDTH: texture_width_reg <= pwdata[14:0];
                REG_MAP_WIDTH:     map_width_reg     <= pwdata[12:0];
                REG_MAP_HEIGHT:    map_height_reg    <= pwdata[12:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_TILE_WIDTH:    prdata = {23'd0, tile_width_reg};
            REG_TILE_HEIGHT:   prdata = {23'd0, tile_height_reg};
            REG_TEXTURE_WIDTH: prdata = {17'd0, texture_width_reg};
            REG_MAP_WIDTH:     prdata = {19'd0, map_width_reg};
            REG_MAP_HEIGHT:    prdata = {19'd0, map_height_reg};
            default:           prdata = 32'd0;
        endcase
    end

    // ---------------------------------------------------------------
    // datapath helpers
    // ---------------------------------------------------------------
    assign mul_prod = {9'd0, mul_a} * {16'd0, mul_b};

    // corner offsets and texture x with saturation
    assign ox     = CORNER_DX[corner_reg] ? tile_width_reg : 9'd0;
    assign oy     = CORNER_DY[corner_reg] ? tile_height_reg : 9'd0;
    assign tx_sum = {1'b0, base_tx_reg} + {16'd0, ox};

    // map cell advance, wraps at the map size or at 4096
    assign col_inc  = {1'b0, cell_col_reg} + 13'd1;
    assign row_inc  = {1'b0, cell_row_reg} + 13'd1;
    assign col_wrap = (col_inc >= map_width_reg) || col_inc[12];
    assign row_wrap = (row_inc >= map_height_reg) || row_inc[12];

    // output register can take a vertex this cycle
    assign out_free = !out_valid_reg || vertex_out.ready;

    assign tile_in.ready = (state_reg == ST_IDLE);

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        cols_next      = cols_reg;
        cols_ok_next   = cols_ok_reg;
        idx_next       = idx_reg;
        tcol_next      = tcol_reg;
        trow_next      = trow_reg;
        base_px_next   = base_px_reg;
        base_py_next   = base_py_reg;
        base_tx_next   = base_tx_reg;
        base_ty_next   = base_ty_reg;
        corner_next    = corner_reg;
        cell_col_next  = cell_col_reg;
        cell_row_next  = cell_row_reg;

        out_valid_next  = out_valid_reg && !vertex_out.ready;
        out_corner_next = out_corner_reg;
        out_pos_x_next  = out_pos_x_reg;
        out_pos_y_next  = out_pos_y_reg;
        out_tex_x_next  = out_tex_x_reg;
        out_tex_y_next  = out_tex_y_reg;
        out_done_next   = out_done_reg;

        div_req = '0;
        mul_a   = 16'd0;
        mul_b   = 9'd0;

        case (state_reg)
            ST_IDLE:
            begin
                if (tile_in.valid)
                begin
                    idx_next   = tile_in.tile_index;
                    state_next = ST_COLS;
                end
            end

            ST_COLS:
            begin
                // tileset column count is cached until its inputs change
                if (cols_ok_reg)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = idx_reg;
                    div_req.divisor  = cols_reg;
                    state_next       = ST_DIV_IDX;
                end
                else if (tile_width_reg == 9'd0)
                begin
                    cols_next    = 15'd1;
                    cols_ok_next = 1'b1;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = {1'b0, texture_width_reg};
                    div_req.divisor  = {6'd0, tile_width_reg};
                    state_next       = ST_DIV_COLS;
                end
            end

            ST_DIV_COLS:
            begin
                if (div_rsp.done)
                begin
                    // texture narrower than one tile still counts as one column
                    if (div_rsp.quotient == 16'd0)
                    begin
                        cols_next = 15'd1;
                    end
                    else
                    begin
                        cols_next = div_rsp.quotient[14:0];
                    end
                    cols_ok_next = 1'b1;
                    state_next   = ST_COLS;
                end
            end

            ST_DIV_IDX:
            begin
                if (div_rsp.done)
                begin
                    tcol_next  = div_rsp.remainder;
                    trow_next  = div_rsp.quotient;
                    state_next = ST_MUL_PX;
                end
            end

            ST_MUL_PX:
            begin
                mul_a        = {4'd0, cell_col_reg};
                mul_b        = tile_width_reg;
                base_px_next = mul_prod[20:0];
                state_next   = ST_MUL_PY;
            end

            ST_MUL_PY:
            begin
                mul_a        = {4'd0, cell_row_reg};
                mul_b        = tile_height_reg;
                base_py_next = mul_prod[20:0];
                state_next   = ST_MUL_TX;
            end

            ST_MUL_TX:
            begin
                mul_a        = {1'b0, tcol_reg};
                mul_b        = tile_width_reg;
                base_tx_next = mul_prod[23:0];
                state_next   = ST_MUL_TY;
            end

            ST_MUL_TY:
            begin
                mul_a        = trow_reg;
                mul_b        = tile_height_reg;
                base_ty_next = mul_prod;
                corner_next  = 3'd0;
                state_next   = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_corner_next = corner_reg;
                    out_pos_x_next  = base_px_reg + {12'd0, ox};
                    out_pos_y_next  = base_py_reg + {12'd0, oy};
                    out_tex_x_next  = (tx_sum > TEX_X_MAX) ? TEX_X_MAX[14:0] : tx_sum[14:0];
                    out_tex_y_next  = base_ty_reg + {16'd0, oy};
                    out_done_next   = (corner_reg == CORNER_LAST);

                    if (corner_reg == CORNER_LAST)
                    begin
                        state_next = ST_IDLE;
                        if (col_wrap)
                        begin
                            cell_col_next = 12'd0;
                            cell_row_next = row_wrap ? 12'd0 : row_inc[11:0];
                        end
                        else
                        begin
                            cell_col_next = col_inc[11:0];
                        end
                    end
                    else
                    begin
                        corner_next = corner_reg + 3'd1;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // a new tile or texture width invalidates the cached column count
        if (cfg_wr && (cfg_idx == REG_TILE_WIDTH || cfg_idx == REG_TEXTURE_WIDTH))
        begin
            cols_ok_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cols_ok_reg   <= 1'b0;
            corner_reg    <= 3'd0;
            cell_col_reg  <= 12'd0;
            cell_row_reg  <= 12'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cols_ok_reg   <= cols_ok_next;
            corner_reg    <= corner_next;
            cell_col_reg  <= cell_col_next;
            cell_row_reg  <= cell_row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cols_reg       <= cols_next;
        idx_reg        <= idx_next;
        tcol_reg       <= tcol_next;
        trow_reg       <= trow_next;
        base_px_reg    <= base_px_next;
        base_py_reg    <= base_py_next;
        base_tx_reg    <= base_tx_next;
        base_ty_reg    <= base_ty_next;
        out_corner_reg <= out_corner_next;
        out_pos_x_reg  <= out_pos_x_next;
        out_pos_y_reg  <= out_pos_y_next;
        out_tex_x_reg  <= out_tex_x_next;
        out_tex_y_reg  <= out_tex_y_next;
        out_done_reg   <= out_done_next;
    end

    assign vertex_out.valid     = out_valid_reg;
    assign vertex_out.corner    = out_corner_reg;
    assign vertex_out.pos_x     = out_pos_x_reg;
    assign vertex_out.pos_y     = out_pos_y_reg;
    assign vertex_out.tex_x     = out_tex_x_reg;
    assign vertex_out.tex_y     = out_tex_y_reg;
    assign vertex_out.tile_done = out_done_reg;

`ifndef SYNTH
    // divider is never relaunched while it is still iterating
    a_div_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // the cached column count is never zero
    a_cols_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cols_ok_reg |-> (cols_reg != 15'd0))
        else $error("tileset column count is zero");

    // leaving the emit phase puts the last corner of the tile in the output register
    a_last_vertex: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && state_next == ST_IDLE)
        |=> (vertex_out.valid && vertex_out.tile_done && vertex_out.corner == CORNER_LAST))
        else $error("tile finished without its last vertex");

    // no new tile is taken until all six vertices have been issued
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (tile_in.valid && tile_in.ready) |=> !tile_in.ready)
        else $error("tile accepted while previous tile in progress");
`endif

endmodule

`default_nettype wire
